### design/rtnp_pkg.sv
`default_nettype none

package rtnp_pkg;

  // serial divider geometry
  localparam int DVD_W = 34;
  localparam int DVS_W = 16;
  localparam int CNT_W = 6;

  // sharp: f * 10595 / 10000 needs the full product width
  localparam logic [CNT_W-1:0] SHARP_ITERS = CNT_W'(DVD_W);
  // duration: 2,000,000 fits in 21 bits, left-aligned in the dividend
  localparam int               DUR_BITS    = 21;
  localparam logic [CNT_W-1:0] DUR_ITERS   = CNT_W'(DUR_BITS);
  localparam logic [DVD_W-1:0] DUR_DVD     = DVD_W'(2000000) << (DVD_W - DUR_BITS);

  localparam logic [13:0]      SHARP_NUM   = 14'd10595;
  localparam logic [DVS_W-1:0] SHARP_DEN   = DVS_W'(10000);

  localparam logic [19:0] FREQ_MAX  = 20'hFFFFF;
  localparam logic [15:0] VAL_MAX   = 16'hFFFF;
  localparam logic [3:0]  OCT_LIMIT = 4'd5;
  localparam logic [3:0]  OCT_MAX   = 4'd15;
  localparam logic [15:0] DEF_DUR   = 16'd4;
  localparam logic [3:0]  DEF_OCT   = 4'd6;

  // characters of interest
  localparam logic [7:0] CH_EOS   = 8'h00;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Z     = 8'h7A;

  // base tones a..g
  localparam logic [9:0] TONE_HZ [0:6] = '{10'd440, 10'd494, 10'd523, 10'd587,
                                           10'd659, 10'd698, 10'd784};

  typedef enum logic [3:0] {
    PH_TITLE,
    PH_HDR_KEY,
    PH_HDR_VAL,
    PH_NOTE_START,
    PH_DUR1,
    PH_DUR2,
    PH_LETTER,
    PH_SHARP,
    PH_DOT,
    PH_OCT,
    PH_NOTE_END
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHARP_START,
    S_SHARP_WAIT,
    S_DOUBLE,
    S_DIV_WAIT,
    S_OUT
  } seq_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### design/rtnp_serdiv.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, dividend taken MSB first.
module rtnp_serdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  rtnp_pkg::div_ctrl_t         ctrl,
  input  logic [rtnp_pkg::DVD_W-1:0]  dividend,
  input  logic [rtnp_pkg::DVS_W-1:0]  divisor,
  output rtnp_pkg::div_stat_t         stat,
  output logic [rtnp_pkg::DVD_W-1:0]  quotient
);
  import rtnp_pkg::*;

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= ctrl.iters;
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DVD_W-2:0], 1'b0};
      rem      <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

  assign stat = '{busy: busy, done: done};

  a_no_restart: assert property (@(posedge clk) disable iff (rst) ctrl.start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

`default_nettype wire

### design/ringtone_text_note_parser_core.sv
`default_nettype none

// Ringtone text note parser. Characters of a ringtone string come in one per
// transaction on the input channel; a zero character ends the string and returns
// the parser registers, header defaults included, to their reset values. The
// title is skipped up to the first ':', the header sets the default octave (o=)
// and note value (d=), and each note closed by ',' or by end of string gives one
// output transaction carrying frequency, duration and the zero-duration flag.
// Input is taken only while the sequencer is idle; an ordinary character leaves
// it idle. For a '#' the frequency is multiplied by 10595 into a register as the
// character is taken, then divided by 10000 in the bit-serial divider, 34 steps.
// A note end first runs k doubling steps, one per cycle, k being the note's
// octave minus 5 when above 5, then 21 divider steps for 2,000,000 / note value,
// then the output load; a zero note value skips the divider. The output register
// holds a finished note while the next characters are taken; a note end waits in
// the output step only while the previous note is still held.
module ringtone_text_note_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] frequency,
  output logic [21:0] duration,
  output logic        zero_duration
);
  import rtnp_pkg::*;

  // sequencer and parser registers
  seq_t        state, state_next;
  phase_t      phase, phase_next;
  logic [15:0] def_dur, def_dur_next;
  logic [3:0]  def_oct, def_oct_next;
  logic [7:0]  header_letter, header_letter_next;
  logic [15:0] header_value, header_value_next;
  logic [15:0] note_value, note_value_next;
  logic [3:0]  note_octave, note_octave_next;
  logic [19:0] note_freq, note_freq_next;
  logic        dotted, dotted_next;
  logic        clr_pend, clr_pend_next;
  logic        out_valid_next;

  // payload registers
  logic [DVD_W-1:0] prod;
  logic [21:0]      res_dur;
  logic             res_zero;

  // character decode results
  phase_t      p_phase;
  logic [7:0]  p_hlet;
  logic [15:0] p_hval;
  logic [15:0] p_ddur;
  logic [3:0]  p_doct;
  logic [15:0] p_nval;
  logic [3:0]  p_noct;
  logic [19:0] p_nfreq;
  logic        p_dot;
  logic        want_sharp;
  logic        want_emit;
  logic        want_clear;

  logic        accept;
  logic        c_dig;
  logic        c_low;
  logic [3:0]  dig;
  logic [2:0]  letter_idx;

  logic        do_clear;
  logic        out_load;
  logic        res_load_zero;
  logic        res_load_div;
  logic [20:0] dbl;
  logic [22:0] dur_x3;
  logic [21:0] dur_calc;

  // divider interface
  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_quot;

  // v * 10 + d, saturating at 65535
  function automatic logic [15:0] acc10(input logic [15:0] v, input logic [3:0] d);
    logic [19:0] r;
    r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, d};
    return (|r[19:16]) ? VAL_MAX : r[15:0];
  endfunction

  assign accept     = in_valid && in_ready;
  assign c_dig      = character inside {[CH_ZERO:CH_NINE]};
  assign c_low      = character inside {[CH_A:CH_Z]};
  assign dig        = character[3:0];
  assign letter_idx = 3'(character - CH_A);

  // Per-character parse, used only when a transaction is taken in idle.
  // The note phases fall through one another the way the grammar allows
  // skipping optional parts.
  always_comb begin
    p_phase    = phase;
    p_hlet     = header_letter;
    p_hval     = header_value;
    p_ddur     = def_dur;
    p_doct     = def_oct;
    p_nval     = note_value;
    p_noct     = note_octave;
    p_nfreq    = note_freq;
    p_dot      = dotted;
    want_sharp = 1'b0;
    want_emit  = 1'b0;
    want_clear = 1'b0;
    if (character == CH_EOS) begin
      want_clear = 1'b1;
      want_emit  = (phase == PH_SHARP) || (phase == PH_DOT) ||
                   (phase == PH_OCT) || (phase == PH_NOTE_END);
    end else begin
      case (phase)
        PH_HDR_KEY: begin
          if (character == CH_COLON) begin
            p_phase = PH_NOTE_START;
          end else if (c_low) begin
            p_hlet  = character;
            p_hval  = '0;
            p_phase = PH_HDR_VAL;
          end
        end
        PH_HDR_VAL: begin
          if (c_dig) begin
            p_hval = acc10(header_value, dig);
          end else if (character == CH_COLON || character == CH_COMMA) begin
            if (header_letter == CH_O) begin
              p_doct = (header_value > 16'(OCT_MAX)) ? OCT_MAX : header_value[3:0];
            end else if (header_letter == CH_D) begin
              p_ddur = header_value;
            end
            p_phase = (character == CH_COLON) ? PH_NOTE_START : PH_HDR_KEY;
          end
        end
        PH_NOTE_START, PH_DUR1, PH_DUR2, PH_LETTER: begin
          if (phase == PH_NOTE_START) begin
            p_nval = def_dur;
            p_noct = def_oct;
            p_dot  = 1'b0;
          end
          if ((phase == PH_NOTE_START || phase == PH_DUR1) && c_dig) begin
            p_nval  = {12'd0, dig};
            p_phase = PH_DUR2;
          end else if (phase == PH_DUR2 && c_dig) begin
            p_nval  = acc10(note_value, dig);
            p_phase = PH_LETTER;
          end else begin
            // a non-letter keeps the previous frequency
            if (c_low) begin
              if (character == CH_P || character > CH_G) begin
                p_nfreq = '0;
              end else begin
                p_nfreq = {10'd0, TONE_HZ[letter_idx]};
              end
            end
            p_phase = PH_SHARP;
          end
        end
        PH_SHARP, PH_DOT, PH_OCT, PH_NOTE_END: begin
          if (phase == PH_SHARP && character == CH_SHARP) begin
            want_sharp = 1'b1;
            p_phase    = PH_DOT;
          end else if ((phase == PH_SHARP || phase == PH_DOT) && character == CH_DOT) begin
            p_dot   = 1'b1;
            p_phase = PH_OCT;
          end else if (phase != PH_NOTE_END && c_dig) begin
            p_noct  = dig;
            p_phase = PH_NOTE_END;
          end else if (character == CH_COMMA) begin
            want_emit = 1'b1;
            p_phase   = PH_DUR1;
          end
        end
        default: begin
          // title, and any code past the note end
          if (character == CH_COLON) begin
            p_phase = PH_HDR_KEY;
          end
        end
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (want_sharp) begin
            state_next = S_SHARP_START;
          end else if (want_emit) begin
            state_next = S_DOUBLE;
          end
        end
      end
      S_SHARP_START: state_next = S_SHARP_WAIT;
      S_SHARP_WAIT: begin
        if (div_stat.done) begin
          state_next = S_IDLE;
        end
      end
      S_DOUBLE: begin
        if (note_octave <= OCT_LIMIT) begin
          state_next = (note_value == 16'd0) ? S_OUT : S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // 3/2 for a dotted note, truncated
  assign dur_x3   = {2'b00, div_quot[DUR_BITS-1:0]} + {1'b0, div_quot[DUR_BITS-1:0], 1'b0};
  assign dur_calc = dotted ? dur_x3[22:1] : 22'(div_quot[DUR_BITS-1:0]);
  assign dbl      = {note_freq, 1'b0};

  // sequencer outputs and register updates
  always_comb begin
    phase_next         = phase;
    def_dur_next       = def_dur;
    def_oct_next       = def_oct;
    header_letter_next = header_letter;
    header_value_next  = header_value;
    note_value_next    = note_value;
    note_octave_next   = note_octave;
    note_freq_next     = note_freq;
    dotted_next        = dotted;
    clr_pend_next      = clr_pend;
    in_ready           = (state == S_IDLE);
    div_ctrl           = '{start: 1'b0, iters: DUR_ITERS};
    div_dividend       = DUR_DVD;
    div_divisor        = note_value;
    do_clear           = 1'b0;
    out_load           = 1'b0;
    res_load_zero      = 1'b0;
    res_load_div       = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          phase_next         = p_phase;
          def_dur_next       = p_ddur;
          def_oct_next       = p_doct;
          header_letter_next = p_hlet;
          header_value_next  = p_hval;
          note_value_next    = p_nval;
          note_octave_next   = p_noct;
          note_freq_next     = p_nfreq;
          dotted_next        = p_dot;
          // end of string with a pending note clears after the note leaves
          if (want_clear && want_emit) begin
            clr_pend_next = 1'b1;
          end else if (want_clear) begin
            do_clear = 1'b1;
          end
        end
      end
      S_SHARP_START: begin
        div_ctrl     = '{start: 1'b1, iters: SHARP_ITERS};
        div_dividend = prod;
        div_divisor  = SHARP_DEN;
      end
      S_SHARP_WAIT: begin
        if (div_stat.done) begin
          note_freq_next = (|div_quot[DVD_W-1:20]) ? FREQ_MAX : div_quot[19:0];
        end
      end
      S_DOUBLE: begin
        if (note_octave > OCT_LIMIT) begin
          note_freq_next   = dbl[20] ? FREQ_MAX : dbl[19:0];
          note_octave_next = note_octave - 4'd1;
        end else if (note_value == 16'd0) begin
          res_load_zero = 1'b1;
        end else begin
          div_ctrl = '{start: 1'b1, iters: DUR_ITERS};
        end
      end
      S_DIV_WAIT: begin
        res_load_div = div_stat.done;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load      = 1'b1;
          clr_pend_next = 1'b0;
          do_clear      = clr_pend;
        end
      end
      default: ;
    endcase
    if (do_clear) begin
      phase_next         = PH_TITLE;
      def_dur_next       = DEF_DUR;
      def_oct_next       = DEF_OCT;
      header_letter_next = '0;
      header_value_next  = '0;
      note_value_next    = '0;
      note_octave_next   = '0;
      note_freq_next     = '0;
      dotted_next        = 1'b0;
    end
    out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_TITLE;
      def_dur       <= DEF_DUR;
      def_oct       <= DEF_OCT;
      header_letter <= '0;
      header_value  <= '0;
      note_value    <= '0;
      note_octave   <= '0;
      note_freq     <= '0;
      dotted        <= 1'b0;
      clr_pend      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      def_dur       <= def_dur_next;
      def_oct       <= def_oct_next;
      header_letter <= header_letter_next;
      header_value  <= header_value_next;
      note_value    <= note_value_next;
      note_octave   <= note_octave_next;
      note_freq     <= note_freq_next;
      dotted        <= dotted_next;
      clr_pend      <= clr_pend_next;
      out_valid     <= out_valid_next;
    end
  end

  // payload: sharp product, finished duration, output transaction
  always_ff @(posedge clk) begin
    if (accept && want_sharp) begin
      prod <= {14'd0, note_freq} * DVD_W'(SHARP_NUM);
    end
    if (res_load_zero) begin
      res_dur  <= '0;
      res_zero <= 1'b1;
    end else if (res_load_div) begin
      res_dur  <= dur_calc;
      res_zero <= 1'b0;
    end
    if (out_load) begin
      frequency     <= note_freq;
      duration      <= res_dur;
      zero_duration <= res_zero;
    end
  end

  rtnp_serdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
      div_stat.busy |-> !in_ready)
    else $error("input taken while the divider runs");
  a_zero_flag_dur: assert property (@(posedge clk) disable iff (rst)
      out_valid && zero_duration |-> duration == '0)
    else $error("zero-duration note with nonzero duration");
  a_octave_reduced: assert property (@(posedge clk) disable iff (rst)
      state == S_DIV_WAIT |-> note_octave <= OCT_LIMIT)
    else $error("duration divide started before octave doubling finished");

endmodule

`default_nettype wire
